@@ hw/rtl/absnd_pkg.sv @@
// Package for the alternating-bit sender: field widths, action and ack status
// codes, and the request type of the shared adder.
// No dependencies.
`default_nettype none

package absnd_pkg;

    localparam int BYTE_W  = 8;
    localparam int SUM_W   = 13;
    localparam int TIMER_W = 16;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int ALU_W   = 16;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd30;

    // input item kinds
    localparam logic [ACT_W-1:0] ACT_MSG  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

    // ack judgement codes
    localparam logic [STAT_W-1:0] ST_NONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ACCEPT = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/absnd_alu.sv @@
// Shared adder of the alternating-bit sender: running sums, ack check value,
// timer decrement and packet checksum all pass through it.
// Depends on absnd_pkg.
`default_nettype none

module absnd_alu (
    input  wire  absnd_pkg::alu_req_t           req,
    output logic [absnd_pkg::ALU_W-1:0]         sum
);
    import absnd_pkg::*;

    assign sum = req.a + req.b;

endmodule

`default_nettype wire

@@ hw/rtl/absnd_store.sv @@
// Message byte memory: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none

module absnd_store #(
    parameter int DEPTH  = 160,
    parameter int ADDR_W = 8
) (
    input  wire                 clk,
    input  wire                 wr_en,
    input  wire  [ADDR_W-1:0]   wr_addr,
    input  wire  [7:0]          wr_data,
    input  wire                 rd_en,
    input  wire  [ADDR_W-1:0]   rd_addr,
    output logic [7:0]          rd_data
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/alternating_bit_sender.sv @@
// Top level of the alternating-bit (stop-and-wait) sender: sequencer, queue
// bookkeeping, ack judgement, timer and result register.
// Depends on absnd_pkg, absnd_alu, absnd_store.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  item     | item_valid / item_ready    | action data_byte ack_number ack_seq
//           |                            | ack_checksum
//  result   | result_valid / result_ready| tx_valid tx_byte tx_seq tx_checksum
//           |                            | last queue_overflow ack_status
//  config   | cfg_we (no wait)           | cfg_wdata = timeout_ticks
//
// Steps, from the accept, with a free result register: a message byte or tick
// is accepted, takes an adder pass and loads the result; the last byte of an
// ack takes one more adder pass for the check value first. An item that sends a
// packet has the checksum step in place of the result load, then a memory read
// and a result load for each payload byte. Every sum, compare value and timer
// step goes through the one shared adder.
// Reset: rst_n clears all control state at once; the message memory and the
// per-slot sums need no clearing, only queued slots are ever read.
// Stalls: a result waits in the output register; the next item is taken
// meanwhile and the sequencer holds only when it must load another result.
`default_nettype none

module alternating_bit_sender #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int PAYLOAD_BYTES = 20
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // input item
    input  wire                               item_valid,
    output logic                              item_ready,
    input  wire  [absnd_pkg::ACT_W-1:0]       action,
    input  wire  [absnd_pkg::BYTE_W-1:0]      data_byte,
    input  wire                               ack_number,
    input  wire                               ack_seq,
    input  wire  [absnd_pkg::SUM_W-1:0]       ack_checksum,
    // result item
    output logic                              result_valid,
    input  wire                               result_ready,
    output logic                              tx_valid,
    output logic [absnd_pkg::BYTE_W-1:0]      tx_byte,
    output logic                              tx_seq,
    output logic [absnd_pkg::SUM_W-1:0]       tx_checksum,
    output logic                              last,
    output logic                              queue_overflow,
    output logic [absnd_pkg::STAT_W-1:0]      ack_status,
    // configuration
    input  wire                               cfg_we,
    input  wire  [absnd_pkg::TIMER_W-1:0]     cfg_wdata
);
    import absnd_pkg::*;

    localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int MEM_DEPTH = QUEUE_DEPTH * PAYLOAD_BYTES;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,     // ready for an item
        S_ADD1,     // first adder pass: running sum or timer decrement
        S_ADD2,     // ack check value and judgement
        S_CSUM,     // packet checksum, timer load
        S_RD,       // memory read of one packet byte
        S_EMIT,     // load packet byte into result register
        S_EMPTY     // load the single non-packet result
    } state_t;

    state_t state_reg;

    // latched item
    logic [ACT_W-1:0]   act_reg;
    logic [BYTE_W-1:0]  dbyte_reg;
    logic               an_reg;
    logic               as_reg;
    logic [SUM_W-1:0]   acs_reg;

    // queue and protocol state
    logic [SLOT_W-1:0]  head_reg;
    logic [SLOT_W-1:0]  tail_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [IDX_W-1:0]   msg_idx_reg;
    logic [SUM_W-1:0]   msg_sum_reg;
    logic               msg_zero_reg;
    logic               drop_reg;
    logic [IDX_W-1:0]   ack_idx_reg;
    logic [SUM_W-1:0]   ack_sum_reg;
    logic               ack_zero_reg;
    logic               seq_reg;
    logic               await_reg;
    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timeout_reg;

    // per-item result fields
    logic               ovf_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [SUM_W-1:0]   csum_reg;
    logic [IDX_W-1:0]   burst_reg;

    logic [SUM_W-1:0]   sums_reg [QUEUE_DEPTH];

    // shared adder
    alu_req_t           alu_req;
    logic [ALU_W-1:0]   alu_sum;
    logic [SUM_W-1:0]   add13;

    absnd_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    assign add13 = alu_sum[SUM_W-1:0];

    always_comb
    begin
        alu_req = '0;
        unique case (state_reg)
            S_ADD1:
            begin
                unique case (act_reg)
                    ACT_MSG:
                    begin
                        alu_req.a = ALU_W'(msg_sum_reg);
                        alu_req.b = ALU_W'(dbyte_reg);
                    end
                    ACT_ACK:
                    begin
                        alu_req.a = ALU_W'(ack_sum_reg);
                        alu_req.b = ALU_W'(dbyte_reg);
                    end
                    ACT_TICK:
                    begin
                        alu_req.a = ALU_W'(timer_reg);
                        alu_req.b = '1;     // minus one
                    end
                    default:
                    begin
                        alu_req = '0;
                    end
                endcase
            end
            S_ADD2:
            begin
                // ack_seq + ack_number as a two-bit value
                alu_req.a = ALU_W'(ack_sum_reg);
                alu_req.b = ALU_W'({as_reg & an_reg, as_reg ^ an_reg});
            end
            S_CSUM:
            begin
                alu_req.a = ALU_W'(sums_reg[head_reg]);
                alu_req.b = ALU_W'({seq_reg, 1'b0});
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    // message byte decisions
    logic               count_full;
    logic               count_nz;
    logic               byte_zero;
    logic               drop_new;
    logic               msg_last;
    logic               msg_ovf;
    logic               msg_send;
    logic [SUM_W-1:0]   msg_sum_upd;
    logic [SUM_W-1:0]   ack_sum_upd;
    logic               ack_last;
    logic               ack_good;
    logic [SLOT_W-1:0]  tail_inc;
    logic [SLOT_W-1:0]  head_inc;
    logic               burst_last;

    assign count_full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign count_nz    = (count_reg != '0);
    assign byte_zero   = (dbyte_reg == '0);
    assign drop_new    = (msg_idx_reg == '0) ? count_full : drop_reg;
    assign msg_last    = (msg_idx_reg == IDX_W'(PAYLOAD_BYTES - 1));
    assign msg_ovf     = drop_new || count_full;
    assign msg_send    = !await_reg && (!msg_ovf || count_nz);
    assign msg_sum_upd = (!msg_zero_reg && !byte_zero) ? add13 : msg_sum_reg;
    assign ack_sum_upd = (!ack_zero_reg && !byte_zero) ? add13 : ack_sum_reg;
    assign ack_last    = (ack_idx_reg == IDX_W'(PAYLOAD_BYTES - 1));
    assign ack_good    = (an_reg == seq_reg) && (acs_reg == add13);
    assign tail_inc    = (tail_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + SLOT_W'(1);
    assign head_inc    = (head_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + SLOT_W'(1);
    assign burst_last  = (burst_reg == IDX_W'(PAYLOAD_BYTES - 1));

    // message memory
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [BYTE_W-1:0]  mem_rdata;

    assign mem_we    = (state_reg == S_ADD1) && (act_reg == ACT_MSG) && !drop_new;
    assign mem_waddr = ADDR_W'(tail_reg) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(msg_idx_reg);
    assign mem_re    = (state_reg == S_RD);
    assign mem_raddr = ADDR_W'(head_reg) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(burst_reg);

    absnd_store #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (dbyte_reg),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // per-slot payload sums, written when a message is queued
    always_ff @(posedge clk)
    begin
        if (mem_we && msg_last)
        begin
            sums_reg[tail_reg] <= msg_sum_upd;
        end
    end

    // result register: free when empty or being taken this cycle
    logic out_free;
    logic load_result;
    assign out_free    = !result_valid || result_ready;
    assign load_result = out_free && (state_reg == S_EMIT || state_reg == S_EMPTY);
    assign item_ready  = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= ACT_MSG;
            dbyte_reg      <= '0;
            an_reg         <= 1'b0;
            as_reg         <= 1'b0;
            acs_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            msg_idx_reg    <= '0;
            msg_sum_reg    <= '0;
            msg_zero_reg   <= 1'b0;
            drop_reg       <= 1'b0;
            ack_idx_reg    <= '0;
            ack_sum_reg    <= '0;
            ack_zero_reg   <= 1'b0;
            seq_reg        <= 1'b0;
            await_reg      <= 1'b0;
            timer_reg      <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            ovf_reg        <= 1'b0;
            status_reg     <= ST_NONE;
            csum_reg       <= '0;
            burst_reg      <= '0;
            result_valid   <= 1'b0;
            tx_valid       <= 1'b0;
            tx_byte        <= '0;
            tx_seq         <= 1'b0;
            tx_checksum    <= '0;
            last           <= 1'b0;
            queue_overflow <= 1'b0;
            ack_status     <= ST_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end

            // taken and not refilled this cycle
            if (result_valid && result_ready && !load_result)
            begin
                result_valid <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        act_reg    <= action;
                        dbyte_reg  <= data_byte;
                        an_reg     <= ack_number;
                        as_reg     <= ack_seq;
                        acs_reg    <= ack_checksum;
                        ovf_reg    <= 1'b0;
                        status_reg <= ST_NONE;
                        state_reg  <= S_ADD1;
                    end
                end

                S_ADD1:
                begin
                    unique case (act_reg)
                        ACT_MSG:
                        begin
                            if (msg_last)
                            begin
                                ovf_reg <= msg_ovf;
                                if (!msg_ovf)
                                begin
                                    tail_reg  <= tail_inc;
                                    count_reg <= count_reg + COUNT_W'(1);
                                end
                                msg_idx_reg  <= '0;
                                msg_sum_reg  <= '0;
                                msg_zero_reg <= 1'b0;
                                drop_reg     <= 1'b0;
                                state_reg    <= msg_send ? S_CSUM : S_EMPTY;
                            end
                            else
                            begin
                                drop_reg    <= drop_new;
                                msg_sum_reg <= msg_sum_upd;
                                if (!msg_zero_reg && byte_zero)
                                begin
                                    msg_zero_reg <= 1'b1;
                                end
                                msg_idx_reg <= msg_idx_reg + IDX_W'(1);
                                state_reg   <= S_EMPTY;
                            end
                        end
                        ACT_ACK:
                        begin
                            ack_sum_reg <= ack_sum_upd;
                            if (!ack_zero_reg && byte_zero)
                            begin
                                ack_zero_reg <= 1'b1;
                            end
                            if (ack_last)
                            begin
                                state_reg <= S_ADD2;
                            end
                            else
                            begin
                                ack_idx_reg <= ack_idx_reg + IDX_W'(1);
                                state_reg   <= S_EMPTY;
                            end
                        end
                        ACT_TICK:
                        begin
                            if (await_reg && timer_reg <= TIMER_W'(1))
                            begin
                                // expiry: resend the head
                                state_reg <= count_nz ? S_CSUM : S_EMPTY;
                            end
                            else
                            begin
                                if (await_reg)
                                begin
                                    timer_reg <= alu_sum;
                                end
                                state_reg <= S_EMPTY;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_EMPTY;
                        end
                    endcase
                end

                S_ADD2:
                begin
                    ack_idx_reg  <= '0;
                    ack_sum_reg  <= '0;
                    ack_zero_reg <= 1'b0;
                    if (await_reg)
                    begin
                        if (ack_good)
                        begin
                            status_reg <= ST_ACCEPT;
                            if (count_nz)
                            begin
                                head_reg  <= head_inc;
                                count_reg <= count_reg - COUNT_W'(1);
                            end
                            seq_reg   <= !seq_reg;
                            await_reg <= 1'b0;
                            timer_reg <= '0;
                            state_reg <= (count_reg > COUNT_W'(1)) ? S_CSUM : S_EMPTY;
                        end
                        else
                        begin
                            status_reg <= ST_REJECT;
                            state_reg  <= count_nz ? S_CSUM : S_EMPTY;
                        end
                    end
                    else
                    begin
                        state_reg <= S_EMPTY;
                    end
                end

                S_CSUM:
                begin
                    csum_reg  <= add13;
                    await_reg <= 1'b1;
                    timer_reg <= timeout_reg;
                    burst_reg <= '0;
                    state_reg <= S_RD;
                end

                S_RD:
                begin
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        result_valid   <= 1'b1;
                        tx_valid       <= 1'b1;
                        tx_byte        <= mem_rdata;
                        tx_seq         <= seq_reg;
                        tx_checksum    <= csum_reg;
                        last           <= burst_last;
                        queue_overflow <= ovf_reg;
                        ack_status     <= status_reg;
                        if (burst_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            burst_reg <= burst_reg + IDX_W'(1);
                            state_reg <= S_RD;
                        end
                    end
                end

                S_EMPTY:
                begin
                    if (out_free)
                    begin
                        result_valid   <= 1'b1;
                        tx_valid       <= 1'b0;
                        tx_byte        <= '0;
                        tx_seq         <= 1'b0;
                        tx_checksum    <= '0;
                        last           <= 1'b1;
                        queue_overflow <= ovf_reg;
                        ack_status     <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/absnd_checker.sv @@
// Port-level checks of the alternating-bit sender, bound to its top level.
// Depends on absnd_pkg and alternating_bit_sender.
`default_nettype none

module absnd_checker (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               item_valid,
    input  wire                               item_ready,
    input  wire                               result_valid,
    input  wire                               result_ready,
    input  wire                               tx_valid,
    input  wire  [absnd_pkg::BYTE_W-1:0]      tx_byte,
    input  wire                               tx_seq,
    input  wire  [absnd_pkg::SUM_W-1:0]       tx_checksum,
    input  wire                               last,
    input  wire  [absnd_pkg::STAT_W-1:0]      ack_status
);
    import absnd_pkg::*;

    // a stalled result stays offered
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // one item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while previous item is in work");

    // a result without a packet byte is always the final one, with zero fields
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !tx_valid |->
            last && tx_byte == '0 && !tx_seq && tx_checksum == '0)
        else $error("non-packet result malformed");

    // within a packet burst the sequence bit, checksum and ack status do not change
    a_burst_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && tx_valid && !last ##1 result_valid |->
            tx_valid && tx_seq == $past(tx_seq) && tx_checksum == $past(tx_checksum)
            && ack_status == $past(ack_status))
        else $error("packet header changed inside a burst");

endmodule

bind alternating_bit_sender absnd_checker u_absnd_checker (.*);

`default_nettype wire
